FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of the block allocator.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off while reset is low.
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define BBA_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/bba_pkg.sv
// Shared types, constants and a helper function of the bitmap block allocator.
// Depends on nothing; used by the top level, bba_ctrl and bba_checker.
package bba_pkg;

    // Field widths of the request and result items.
    localparam int MODE_W     = 2;
    localparam int BLOCK_W    = 10;
    localparam int ADDR_W     = 22;
    localparam int COUNT_W    = 11;
    localparam int BIT_IDX_W  = 5;
    localparam int BLOCK_SHIFT = 12;

    // One bitmap word holds the usage bits of 32 blocks.
    localparam logic [31:0] FULL_WORD = 32'hffff_ffff;

    typedef logic [MODE_W-1:0] mode_t;

    // Request codes.
    localparam mode_t MODE_ALLOC     = 2'd0;
    localparam mode_t MODE_FREE      = 2'd1;
    localparam mode_t MODE_MARK_USED = 2'd2;
    localparam mode_t MODE_MARK_FREE = 2'd3;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_BIT_WR,
        ST_DONE
    } state_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic                status;
        logic [BLOCK_W-1:0]  granted_block;
        logic [COUNT_W-1:0]  free_count;
    } result_t;

    // Index of the lowest set bit by halving the word five times.
    function automatic logic [BIT_IDX_W-1:0] lowest_one(input logic [31:0] v);
        logic [31:0]          x;
        logic [BIT_IDX_W-1:0] idx;
        x   = v;
        idx = '0;
        if (x[15:0] == 16'd0) begin
            idx[4] = 1'b1;
            x      = x >> 16;
        end
        if (x[7:0] == 8'd0) begin
            idx[3] = 1'b1;
            x      = x >> 8;
        end
        if (x[3:0] == 4'd0) begin
            idx[2] = 1'b1;
            x      = x >> 4;
        end
        if (x[1:0] == 2'd0) begin
            idx[1] = 1'b1;
            x      = x >> 2;
        end
        idx[0] = ~x[0];
        return idx;
    endfunction

endpackage

FILE: rtl/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: sequencer plus output register.
// Depends on bba_pkg and bba_ctrl.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid / s_ready  s_mode, s_block_number
//   m_       out        m_valid / m_ready  m_status, m_granted_block,
//                                          m_granted_address, m_free_count
//
// After reset a clearing pass sets every bitmap word and takes no item.
// A free or mark item with a block in range passes through read, write-back and result.
// An allocate scans the bitmap one word a cycle through the single read port until a
// word holds a clear bit, reading at most WORDS words; with no block free it fails at once.
// One item is worked on at a time; a new item is taken while a finished result waits at m_.
module bitmap_block_allocator #(
    parameter int BLOCKS = 1024,
    parameter int WORDS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bba_pkg::MODE_W-1:0]   s_mode,
    input  logic [bba_pkg::BLOCK_W-1:0]  s_block_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [bba_pkg::BLOCK_W-1:0]  m_granted_block,
    output logic [bba_pkg::ADDR_W-1:0]   m_granted_address,
    output logic [bba_pkg::COUNT_W-1:0]  m_free_count
);

    logic                         res_valid;
    logic                         res_ready;
    bba_pkg::result_t             res;

    logic                         m_valid_reg;
    bba_pkg::result_t             out_reg;

    bba_ctrl #(
        .BLOCKS (BLOCKS),
        .WORDS  (WORDS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_mode  (s_mode),
        .req_block (s_block_number),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register takes a result when it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    // The byte address is the block number times the block size.
    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_granted_block   = out_reg.granted_block;
    assign m_granted_address = {out_reg.granted_block, {bba_pkg::BLOCK_SHIFT{1'b0}}};
    assign m_free_count      = out_reg.free_count;

endmodule

FILE: rtl/bba_bitmap_ram.sv
// Bitmap word store: one write port and one read port with registered read data.
// Depends on nothing; instantiated by bba_ctrl.
module bba_bitmap_ram #(
    parameter int WORDS  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bba_ctrl.sv
// Request sequencer of the block allocator: clearing pass, word scan and
// read-modify-write of single bits. Depends on bba_pkg and bba_bitmap_ram.
module bba_ctrl #(
    parameter int BLOCKS = 1024,
    parameter int WORDS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  bba_pkg::mode_t                req_mode,
    input  logic [bba_pkg::BLOCK_W-1:0]   req_block,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bba_pkg::result_t              res
);

    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SIDX_W = $clog2(WORDS + 1);
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int GBLK_W = WIDX_W + bba_pkg::BIT_IDX_W;

    bba_pkg::state_t              state_reg, state_next;
    logic [WIDX_W-1:0]            clr_idx_reg;
    bba_pkg::mode_t               mode_reg;
    logic [bba_pkg::BLOCK_W-1:0]  blk_reg;
    logic [SIDX_W-1:0]            issue_idx_reg;
    logic                         chk_valid_reg;
    logic [WIDX_W-1:0]            chk_idx_reg;
    logic                         status_reg;
    logic [bba_pkg::BLOCK_W-1:0]  gblk_reg;
    logic [CNT_W-1:0]             used_count_reg;

    logic                         wr_en;
    logic [WIDX_W-1:0]            wr_addr;
    logic [31:0]                  wr_data;
    logic                         rd_en;
    logic [WIDX_W-1:0]            rd_addr;
    logic [31:0]                  rd_data;

    logic                         accept;
    logic                         clr_last;
    logic                         pool_empty;
    logic                         req_in_range;
    logic                         found;
    logic                         more_words;
    logic [31:0]                  alloc_mask;
    logic [bba_pkg::BIT_IDX_W-1:0] alloc_bit;
    logic [GBLK_W-1:0]            gblk_full;
    logic [31:0]                  bit_mask;
    logic                         bit_was;
    logic                         bit_set;
    logic                         cnt_inc;
    logic                         cnt_dec;

    bba_bitmap_ram #(
        .WORDS  (WORDS),
        .ADDR_W (WIDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decoded conditions of the request and of the word under test.
    assign accept       = req_valid && req_ready;
    assign clr_last     = (clr_idx_reg == WIDX_W'(WORDS - 1));
    assign pool_empty   = (used_count_reg >= CNT_W'(BLOCKS));
    assign req_in_range = ({22'd0, req_block} < 32'(BLOCKS)) &&
                          ({27'd0, req_block[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W]}
                           < 32'(WORDS));
    assign found        = chk_valid_reg && (rd_data != bba_pkg::FULL_WORD);
    assign more_words   = (issue_idx_reg < SIDX_W'(WORDS));
    assign alloc_mask   = ~rd_data & (rd_data + 32'd1);
    assign alloc_bit    = bba_pkg::lowest_one(~rd_data);
    assign gblk_full    = {chk_idx_reg, alloc_bit};
    assign bit_mask     = 32'd1 << blk_reg[bba_pkg::BIT_IDX_W-1:0];
    assign bit_was      = (rd_data & bit_mask) != 32'd0;
    assign bit_set      = (mode_reg == bba_pkg::MODE_MARK_USED);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (req_valid) begin
                    if (req_mode == bba_pkg::MODE_ALLOC) begin
                        state_next = pool_empty ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
                    end else begin
                        state_next = req_in_range ? bba_pkg::ST_BIT_WR : bba_pkg::ST_DONE;
                    end
                end
            end
            bba_pkg::ST_SCAN: begin
                if (found || !more_words) begin
                    state_next = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_BIT_WR: begin
                state_next = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory controls, handshakes and count updates.
    always_comb begin
        req_ready = 1'b0;
        res_valid = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = clr_idx_reg;
        wr_data   = bba_pkg::FULL_WORD;
        rd_en     = 1'b0;
        rd_addr   = issue_idx_reg[WIDX_W-1:0];
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
            end
            bba_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                rd_en     = req_valid;
                rd_addr   = WIDX_W'(req_block >> bba_pkg::BIT_IDX_W);
            end
            bba_pkg::ST_SCAN: begin
                if (found) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_idx_reg;
                    wr_data = rd_data | alloc_mask;
                    cnt_inc = 1'b1;
                end else if (more_words) begin
                    rd_en = 1'b1;
                end
            end
            bba_pkg::ST_BIT_WR: begin
                wr_addr = WIDX_W'(blk_reg >> bba_pkg::BIT_IDX_W);
                if (bit_set && !bit_was) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data | bit_mask;
                    cnt_inc = 1'b1;
                end else if (!bit_set && bit_was) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data & ~bit_mask;
                    cnt_dec = 1'b1;
                end
            end
            bba_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bba_pkg::ST_CLEAR;
            clr_idx_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            used_count_reg <= CNT_W'(BLOCKS);
        end else begin
            state_reg <= state_next;
            if (state_reg == bba_pkg::ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + WIDX_W'(1);
            end
            if (accept) begin
                chk_valid_reg <= 1'b0;
            end else if (state_reg == bba_pkg::ST_SCAN && rd_en) begin
                chk_valid_reg <= 1'b1;
            end
            if (cnt_inc) begin
                used_count_reg <= used_count_reg + CNT_W'(1);
            end else if (cnt_dec) begin
                used_count_reg <= used_count_reg - CNT_W'(1);
            end
        end
    end

    // Request fields, scan position and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg      <= req_mode;
            blk_reg       <= req_block;
            issue_idx_reg <= '0;
            gblk_reg      <= '0;
            status_reg    <= (req_mode == bba_pkg::MODE_ALLOC && pool_empty) ?
                             bba_pkg::STATUS_FULL : bba_pkg::STATUS_OK;
        end else if (state_reg == bba_pkg::ST_SCAN) begin
            if (found) begin
                gblk_reg <= bba_pkg::BLOCK_W'(gblk_full);
            end else if (more_words) begin
                issue_idx_reg <= issue_idx_reg + SIDX_W'(1);
                chk_idx_reg   <= issue_idx_reg[WIDX_W-1:0];
            end else begin
                status_reg <= bba_pkg::STATUS_FULL;
            end
        end
    end

    assign res.status        = status_reg;
    assign res.granted_block = gblk_reg;
    assign res.free_count    = bba_pkg::COUNT_W'(CNT_W'(BLOCKS) - used_count_reg);

endmodule

FILE: rtl/bba_checker.sv
// Port-level checks of the bitmap block allocator and the bind that attaches them.
// Depends on bba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bba_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_status,
    input logic [bba_pkg::BLOCK_W-1:0]  m_granted_block,
    input logic [bba_pkg::ADDR_W-1:0]   m_granted_address,
    input logic [bba_pkg::COUNT_W-1:0]  m_free_count
);

    // The clearing pass follows reset, so no item is taken right after it.
    `BBA_ASSERT_ALL(a_no_accept_after_reset, aclk, !aresetn |=> !s_ready,
                    "item taken during clearing pass")

    // The address shown always belongs to the block shown.
    `BBA_ASSERT(a_addr_matches_block, aclk, aresetn,
                m_valid |-> (m_granted_address == {m_granted_block, 12'd0}),
                "granted address does not match granted block")

    // A failed allocate grants nothing and can only happen with no block free.
    `BBA_ASSERT(a_fail_means_empty, aclk, aresetn,
                (m_valid && m_status == bba_pkg::STATUS_FULL) |->
                (m_granted_block == '0 && m_free_count == '0),
                "failed allocate with a free block or a grant")

    // A stalled result holds until it is taken.
    `BBA_ASSERT(a_result_holds, aclk, aresetn,
                (m_valid && !m_ready) |=> (m_valid && $stable(m_status) &&
                $stable(m_granted_block) && $stable(m_free_count)),
                "stalled result changed")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
